/* hdl/stw_pkg.sv */
// Shared types and constants for the stopwatch/countdown timer core.
// Used by stw_digits and stopwatch_countdown_timer_core; no dependencies.
`default_nettype none
package stw_pkg;

  localparam int TimeW = 23;

  localparam logic [TimeW-1:0] TIME_MAX_MS = 23'd5940000;

  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_START  = 3'd1;
  localparam logic [2:0] CMD_END    = 3'd2;
  localparam logic [2:0] CMD_PAUSE  = 3'd3;
  localparam logic [2:0] CMD_RESUME = 3'd4;
  localparam logic [2:0] CMD_ADD    = 3'd5;
  localparam logic [2:0] CMD_SET    = 3'd6;

  localparam logic [1:0] UNIT_MS  = 2'd0;
  localparam logic [1:0] UNIT_S   = 2'd1;
  localparam logic [1:0] UNIT_MIN = 2'd2;

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_MEASURE = 2'd1;
  localparam logic [1:0] MODE_ENDED   = 2'd2;

  localparam logic signed [23:0] AMT_MS_MAX  = 24'sd5940000;
  localparam logic signed [23:0] AMT_S_MAX   = 24'sd5940;
  localparam logic signed [23:0] AMT_MIN_MAX = 24'sd99;
  localparam logic signed [23:0] MS_PER_SEC  = 24'sd1000;
  localparam logic signed [23:0] MS_PER_MIN  = 24'sd60000;

  localparam logic [16:0] MIN_RECIP = 17'd71582;
  localparam logic [16:0] SEC_RECIP = 17'd67108;

  typedef struct packed {
    logic             accepted;
    logic [1:0]       run_state;
    logic             expired;
    logic [TimeW-1:0] time_ms;
    logic [TimeW-1:0] pause_ms;
  } stat_t;

  typedef struct packed {
    logic [3:0] min_tens;
    logic [3:0] min_ones;
    logic [2:0] sec_tens;
    logic [3:0] sec_ones;
    logic [3:0] ms_hundreds;
    logic [3:0] ms_tens;
    logic [3:0] ms_ones;
  } digits_t;

endpackage
`default_nettype wire

/* hdl/stopwatch_countdown_timer_core.sv */
// Millisecond stopwatch with countdown limit, pause and time correction.
// One word per cycle while out_ready does not stall the pipeline.
// The state update for a word is registered in the stage after its input register;
// the digit split follows in a five-stage pipeline, stalled as one by out_ready.
// Reset: idle, paused, all counts and the limit zero, pipeline empty.
// Depends on stw_pkg and stw_digits.
`default_nettype none
module stopwatch_countdown_timer_core import stw_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [TimeW-1:0]  cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        cmd,
  input  wire logic signed [23:0] amount,
  input  wire logic [1:0]        amount_unit,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   accepted,
  output logic [1:0]             run_state,
  output logic                   expired,
  output logic [TimeW-1:0]       time_ms,
  output logic [TimeW-1:0]       pause_ms,
  output logic [3:0]             min_tens,
  output logic [3:0]             min_ones,
  output logic [2:0]             sec_tens,
  output logic [3:0]             sec_ones,
  output logic [3:0]             ms_hundreds,
  output logic [3:0]             ms_tens,
  output logic [3:0]             ms_ones
);

  logic              advance;
  logic [TimeW-1:0]  limit;

  logic              in_vld;
  logic [2:0]        in_cmd;
  logic signed [23:0] in_ms;
  logic              in_unit_ok;

  logic signed [23:0] amt_lim;
  logic signed [23:0] amt_scale;
  logic signed [23:0] amt_ms;
  logic              unit_ok;

  logic [1:0]        run_mode, run_mode_next;
  logic              paused, paused_next;
  logic [TimeW-1:0]  elapsed, elapsed_next;
  logic [TimeW-1:0]  pause_cnt, pause_cnt_next;
  logic [TimeW-1:0]  shown, shown_next;
  logic              acc_next, exp_next;

  logic [TimeW-1:0]  elapsed_inc;
  logic [TimeW-1:0]  pause_inc;
  logic [TimeW-1:0]  base;
  logic signed [25:0] corr_sum;
  logic [TimeW-1:0]  corr_val;
  logic              allow;

  logic              r1_vld;
  stat_t             r1_stat;
  stat_t             o_stat;
  digits_t           o_dig;

  assign advance   = !out_valid || out_ready;
  assign in_ready  = advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= '0;
    end else if (cfg_valid) begin
      limit <= (cfg_data > TIME_MAX_MS) ? TIME_MAX_MS : cfg_data;
    end
  end

  always_comb begin
    amt_lim   = amount;
    amt_scale = 24'sd1;
    unit_ok   = 1'b1;
    unique case (amount_unit)
      UNIT_MS: begin
        if (amount > AMT_MS_MAX) amt_lim = AMT_MS_MAX;
        else if (amount < -AMT_MS_MAX) amt_lim = -AMT_MS_MAX;
      end
      UNIT_S: begin
        amt_scale = MS_PER_SEC;
        if (amount > AMT_S_MAX) amt_lim = AMT_S_MAX;
        else if (amount < -AMT_S_MAX) amt_lim = -AMT_S_MAX;
      end
      UNIT_MIN: begin
        amt_scale = MS_PER_MIN;
        if (amount > AMT_MIN_MAX) amt_lim = AMT_MIN_MAX;
        else if (amount < -AMT_MIN_MAX) amt_lim = -AMT_MIN_MAX;
      end
      default: begin
        amt_lim = '0;
        unit_ok = 1'b0;
      end
    endcase
    amt_ms = amt_lim * amt_scale;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (advance) begin
      in_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      in_cmd     <= cmd;
      in_ms      <= amt_ms;
      in_unit_ok <= unit_ok;
    end
  end

  always_comb begin
    elapsed_inc = (elapsed >= TIME_MAX_MS) ? TIME_MAX_MS : elapsed + 23'd1;
    pause_inc   = (pause_cnt >= TIME_MAX_MS) ? TIME_MAX_MS : pause_cnt + 23'd1;
    base        = (in_cmd == CMD_ADD) ? elapsed : '0;
    corr_sum    = $signed({3'd0, base}) + 26'(in_ms);
    if (corr_sum < 26'sd0) corr_val = '0;
    else if (corr_sum > $signed({3'd0, TIME_MAX_MS})) corr_val = TIME_MAX_MS;
    else corr_val = corr_sum[TimeW-1:0];
    allow = in_unit_ok && !(run_mode == MODE_MEASURE && (paused || limit != '0));

    run_mode_next  = run_mode;
    paused_next    = paused;
    elapsed_next   = elapsed;
    pause_cnt_next = pause_cnt;
    shown_next     = shown;
    acc_next       = 1'b0;
    exp_next       = 1'b0;

    unique case (in_cmd)
      CMD_TICK: begin
        acc_next = 1'b1;
        if (run_mode == MODE_MEASURE) begin
          if (paused) begin
            pause_cnt_next = pause_inc;
          end else begin
            elapsed_next = elapsed_inc;
            if (limit == '0) begin
              shown_next = elapsed_inc;
            end else if (limit > elapsed_inc) begin
              shown_next = limit - elapsed_inc;
            end else begin
              shown_next    = '0;
              run_mode_next = MODE_ENDED;
              exp_next      = 1'b1;
            end
          end
        end
      end
      CMD_START: begin
        if (run_mode != MODE_MEASURE) begin
          acc_next       = 1'b1;
          elapsed_next   = '0;
          pause_cnt_next = '0;
          paused_next    = 1'b0;
          run_mode_next  = MODE_MEASURE;
        end
      end
      CMD_END: begin
        acc_next      = 1'b1;
        run_mode_next = MODE_ENDED;
      end
      CMD_PAUSE: begin
        acc_next       = 1'b1;
        paused_next    = 1'b1;
        pause_cnt_next = '0;
      end
      CMD_RESUME: begin
        acc_next       = 1'b1;
        paused_next    = 1'b0;
        pause_cnt_next = '0;
      end
      CMD_ADD, CMD_SET: begin
        if (allow) begin
          acc_next     = 1'b1;
          elapsed_next = corr_val;
          shown_next   = corr_val;
          if (in_cmd == CMD_SET) pause_cnt_next = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode  <= MODE_IDLE;
      paused    <= 1'b1;
      elapsed   <= '0;
      pause_cnt <= '0;
      shown     <= '0;
      r1_vld    <= 1'b0;
    end else if (advance) begin
      r1_vld <= in_vld;
      if (in_vld) begin
        run_mode  <= run_mode_next;
        paused    <= paused_next;
        elapsed   <= elapsed_next;
        pause_cnt <= pause_cnt_next;
        shown     <= shown_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_vld) begin
      r1_stat.accepted  <= acc_next;
      r1_stat.run_state <= run_mode_next;
      r1_stat.expired   <= exp_next;
      r1_stat.time_ms   <= shown_next;
      r1_stat.pause_ms  <= pause_cnt_next;
    end
  end

  stw_digits u_digits (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .vld_in     (r1_vld),
    .stat_in    (r1_stat),
    .vld_out    (out_valid),
    .stat_out   (o_stat),
    .digits_out (o_dig)
  );

  assign accepted    = o_stat.accepted;
  assign run_state   = o_stat.run_state;
  assign expired     = o_stat.expired;
  assign time_ms     = o_stat.time_ms;
  assign pause_ms    = o_stat.pause_ms;
  assign min_tens    = o_dig.min_tens;
  assign min_ones    = o_dig.min_ones;
  assign sec_tens    = o_dig.sec_tens;
  assign sec_ones    = o_dig.sec_ones;
  assign ms_hundreds = o_dig.ms_hundreds;
  assign ms_tens     = o_dig.ms_tens;
  assign ms_ones     = o_dig.ms_ones;

  a_expired_shows_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && expired |-> time_ms == '0 && run_state == MODE_ENDED)
    else $error("expiry without zero time or ended state");

  a_counts_saturate: assert property (@(posedge clk) disable iff (rst)
    elapsed <= TIME_MAX_MS && pause_cnt <= TIME_MAX_MS && shown <= TIME_MAX_MS)
    else $error("count above 99 minutes");

  a_word_enters_pipe: assert property (@(posedge clk) disable iff (rst)
    in_vld && advance |=> r1_vld)
    else $error("word lost at state stage");

  a_digits_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sec_tens <= 3'd5 && min_tens <= 4'd9 && ms_hundreds <= 4'd9)
    else $error("digit out of range");

endmodule
`default_nettype wire

/* hdl/stw_digits.sv */
// Decimal split of the shown time into minute, second and millisecond digits.
// Five register stages under a common advance enable; uses stw_pkg.
`default_nettype none
module stw_digits import stw_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    advance,
  input  wire logic    vld_in,
  input  wire stat_t   stat_in,
  output logic         vld_out,
  output stat_t        stat_out,
  output digits_t      digits_out
);

  function automatic logic [7:0] split10(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  tens;
    logic [6:0]  ones;
    p    = {8'd0, v} * 15'd205;
    tens = p[14:11];
    ones = v - 7'({3'd0, tens} * 7'd10);
    return {tens, ones[3:0]};
  endfunction

  logic        a_vld, b_vld, c_vld, d_vld;
  stat_t       a_stat, b_stat, c_stat, d_stat;
  logic [6:0]  a_qest;
  logic [6:0]  b_mins;
  logic [15:0] b_rem;
  logic [5:0]  c_sest;
  logic [15:0] c_rem;
  logic [7:0]  c_mdig;
  logic [5:0]  d_secs;
  logic [9:0]  d_msec;
  logic [7:0]  d_mdig;

  logic [39:0] min_prod;
  logic [22:0] min_back;
  logic [22:0] min_rem0;
  logic [32:0] sec_prod;
  logic [15:0] sec_back;
  logic [15:0] sec_rem0;
  logic [15:0] hun_prod;
  logic [3:0]  hun;
  logic [6:0]  ms_low;
  logic [7:0]  sdig, ldig;

  always_comb begin
    min_prod = {17'd0, stat_in.time_ms} * {23'd0, MIN_RECIP};
    min_back = {16'd0, a_qest} * 23'd60000;
    min_rem0 = a_stat.time_ms - min_back;
    sec_prod = {17'd0, b_rem} * {16'd0, SEC_RECIP};
    sec_back = {10'd0, c_sest} * 16'd1000;
    sec_rem0 = c_rem - sec_back;
    hun_prod = {6'd0, d_msec} * 16'd41;
    hun      = hun_prod[15:12];
    ms_low   = 7'(d_msec - 10'({6'd0, hun} * 10'd100));
    sdig     = split10({1'b0, d_secs});
    ldig     = split10(ms_low);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld   <= 1'b0;
      b_vld   <= 1'b0;
      c_vld   <= 1'b0;
      d_vld   <= 1'b0;
      vld_out <= 1'b0;
    end else if (advance) begin
      a_vld   <= vld_in;
      b_vld   <= a_vld;
      c_vld   <= b_vld;
      d_vld   <= c_vld;
      vld_out <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_stat <= stat_in;
      a_qest <= min_prod[38:32];

      b_stat <= a_stat;
      if (min_rem0 >= 23'd60000) begin
        b_mins <= a_qest + 7'd1;
        b_rem  <= 16'(min_rem0 - 23'd60000);
      end else begin
        b_mins <= a_qest;
        b_rem  <= min_rem0[15:0];
      end

      c_stat <= b_stat;
      c_sest <= sec_prod[31:26];
      c_rem  <= b_rem;
      c_mdig <= split10(b_mins);

      d_stat <= c_stat;
      d_mdig <= c_mdig;
      if (sec_rem0 >= 16'd1000) begin
        d_secs <= c_sest + 6'd1;
        d_msec <= 10'(sec_rem0 - 16'd1000);
      end else begin
        d_secs <= c_sest;
        d_msec <= sec_rem0[9:0];
      end

      stat_out               <= d_stat;
      digits_out.min_tens    <= d_mdig[7:4];
      digits_out.min_ones    <= d_mdig[3:0];
      digits_out.sec_tens    <= sdig[6:4];
      digits_out.sec_ones    <= sdig[3:0];
      digits_out.ms_hundreds <= hun;
      digits_out.ms_tens     <= ldig[7:4];
      digits_out.ms_ones     <= ldig[3:0];
    end
  end

endmodule
`default_nettype wire
